// ===== src/spq_pkg.sv =====
package spq_pkg;

	// Default sizes
	localparam int unsigned SPQ_QUEUE_DEPTH   = 256;
	localparam int unsigned SPQ_PRIORITY_BITS = 32;
	localparam int unsigned SPQ_PAYLOAD_BITS  = 9;

	// Request kind carried on the input side
	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} spq_req_t;

	// Operation broadcast to every cell in the chain
	typedef struct packed {
		logic ins;
		logic rem;
	} spq_op_t;

endpackage

// ===== src/sorted_priority_queue.sv =====
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle unless m_axis_tready stalls; every cell
// compares with the broadcast priority and shifts with neighbors in one step.
// Reset clears the entry count and the result valid flag; stored entries and
// result fields are not cleared, since only entries below the count are read.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH   = SPQ_QUEUE_DEPTH,
	parameter int unsigned PRIORITY_BITS = SPQ_PRIORITY_BITS,
	parameter int unsigned PAYLOAD_BITS  = SPQ_PAYLOAD_BITS,
	localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1),
	localparam int unsigned IN_W   = ((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_RAW = PAYLOAD_BITS + CNT_W + 3,
	localparam int unsigned OUT_W  = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// priority_req, payload
	input  logic [IN_W-1:0]  s_axis_tdata,
	// req_type
	input  logic             s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// removed_valid, removed_payload, insert_dropped, queue_empty, queue_count
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

	logic                     accept;
	spq_req_t                 req;
	logic [PRIORITY_BITS-1:0] req_prio;
	logic [PAYLOAD_BITS-1:0]  req_payload;
	spq_op_t                  op;
	logic                     dropped;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;

	logic                     out_valid_q;
	logic                     rem_valid_q;
	logic [PAYLOAD_BITS-1:0]  rem_payload_q;
	logic                     dropped_q;
	logic                     empty_q;
	logic [CNT_W-1:0]         count_out_q;

	logic [QUEUE_DEPTH-1:0]   occupied;
	logic [QUEUE_DEPTH-1:0]   stay;
	logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0]  cell_tag  [QUEUE_DEPTH];

	// Unpack the request
	assign req         = spq_req_t'(s_axis_tuser);
	assign req_prio    = s_axis_tdata[PRIORITY_BITS-1:0];
	assign req_payload = s_axis_tdata[PRIORITY_BITS +: PAYLOAD_BITS];

	// Take a request whenever the result register frees up this cycle
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Decode the operation against the current fill
	always_comb begin
		op         = '0;
		dropped    = 1'b0;
		count_next = count_q;
		if (accept) begin
			unique case (req)
				REQ_INSERT: begin
					if (count_q == FULL_COUNT) begin
						dropped = 1'b1;
					end else begin
						op.ins     = 1'b1;
						count_next = count_q + CNT_W'(1);
					end
				end
				REQ_REMOVE: begin
					if (count_q != '0) begin
						op.rem     = 1'b1;
						count_next = count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Track the fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Build the chain of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                     l_stay;
		logic [PRIORITY_BITS-1:0] l_prio;
		logic [PAYLOAD_BITS-1:0]  l_tag;
		logic [PRIORITY_BITS-1:0] r_prio;
		logic [PAYLOAD_BITS-1:0]  r_tag;

		assign occupied[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign l_stay = 1'b1;
			assign l_prio = '0;
			assign l_tag  = '0;
		end else begin : g_body
			assign l_stay = stay[i-1];
			assign l_prio = cell_prio[i-1];
			assign l_tag  = cell_tag[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_prio = '0;
			assign r_tag  = '0;
		end else begin : g_next
			assign r_prio = cell_prio[i+1];
			assign r_tag  = cell_tag[i+1];
		end

		spq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk          (clk),
			.op           (op),
			.occupied     (occupied[i]),
			.new_prio     (req_prio),
			.new_payload  (req_payload),
			.left_stay    (l_stay),
			.left_prio    (l_prio),
			.left_payload (l_tag),
			.right_prio   (r_prio),
			.right_payload(r_tag),
			.stay         (stay[i]),
			.prio         (cell_prio[i]),
			.tag          (cell_tag[i])
		);
	end

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_valid_q   <= op.rem;
			rem_payload_q <= op.rem ? cell_tag[0] : '0;
			dropped_q     <= dropped;
			empty_q       <= (count_next == '0);
			count_out_q   <= count_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({count_out_q, empty_q, dropped_q, rem_payload_q,
		rem_valid_q});

endmodule

// ===== src/spq_cell.sv =====
module spq_cell
	import spq_pkg::*;
#(
	parameter int unsigned PRIORITY_BITS = SPQ_PRIORITY_BITS,
	parameter int unsigned PAYLOAD_BITS  = SPQ_PAYLOAD_BITS
) (
	input  logic                     clk,
	input  spq_op_t                  op,
	input  logic                     occupied,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic [PAYLOAD_BITS-1:0]  new_payload,
	input  logic                     left_stay,
	input  logic [PRIORITY_BITS-1:0] left_prio,
	input  logic [PAYLOAD_BITS-1:0]  left_payload,
	input  logic [PRIORITY_BITS-1:0] right_prio,
	input  logic [PAYLOAD_BITS-1:0]  right_payload,
	output logic                     stay,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic [PAYLOAD_BITS-1:0]  tag
);

	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]  tag_q;

	// Keep the entry in place when it sorts at or before the new one
	assign stay = occupied && (prio_q <= new_prio);
	assign prio = prio_q;
	assign tag  = tag_q;

	// Hold, take the new entry, or shift from a neighbor
	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (!stay) begin
				if (left_stay) begin
					prio_q <= new_prio;
					tag_q  <= new_payload;
				end else begin
					prio_q <= left_prio;
					tag_q  <= left_payload;
				end
			end
		end else if (op.rem) begin
			prio_q <= right_prio;
			tag_q  <= right_payload;
		end
	end

endmodule
